>>> hdl/xbr_pkg.sv
// Shared constants, codes and controller/datapath interface types of the bounded random unit.
`default_nettype none

package xbr_pkg;

    // Splitmix64 seed expansion constants.
    localparam logic [63:0] MIX_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
    localparam int unsigned MIX_SHIFT_A = 30;
    localparam int unsigned MIX_SHIFT_B = 27;
    localparam int unsigned MIX_SHIFT_C = 31;

    // Item kinds carried on the input tuser.
    localparam logic [1:0] KIND_RESEED = 2'd0;
    localparam logic [1:0] KIND_RAW    = 2'd1;
    localparam logic [1:0] KIND_RANGE  = 2'd2;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned S_TDATA_W = 3 * WORD_W;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_SEED,
        OP_SEED_ZERO,
        OP_MIX_ADD,
        OP_XOR,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_MUL3,
        OP_STORE,
        OP_DRAW,
        OP_SPAN_MUL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_RES_RAW,
        OP_RES_RANGE,
        OP_RES_BAD,
        OP_RES_ZERO
    } xbr_op_t;

    typedef struct packed {
        xbr_op_t op;
        logic    round;     // 0: first mixing round, 1: second mixing round
    } xbr_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       range_bad;
        logic       low_lt_span;
        logic       low_lt_limit;
    } xbr_status_t;

endpackage

`default_nettype wire

>>> hdl/xbr_datapath.sv
// Datapath: generator state, splitmix expansion, shared multiplier, remainder unit, result register.
`default_nettype none

module xbr_datapath (
    input  wire logic                            aclk,
    input  wire xbr_pkg::xbr_cmd_t               cmd,
    input  wire logic [xbr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [xbr_pkg::KIND_W-1:0]      s_tuser,
    output xbr_pkg::xbr_status_t                 status,
    output logic [xbr_pkg::WORD_W-1:0]           res_value,
    output logic                                 res_bad
);

    logic [1:0]  kind_reg;
    logic [31:0] seed_reg;
    logic [31:0] start_reg;
    logic [31:0] end_reg;
    logic [31:0] gen_reg [4];
    logic [63:0] acc_reg;
    logic [63:0] z_reg;
    logic [63:0] mac_reg;
    logic [63:0] prod_reg;
    logic [31:0] draw_reg;
    logic [31:0] rem_reg;
    logic [31:0] div_reg;
    logic [31:0] value_reg;
    logic        bad_reg;

    logic [31:0] span;
    logic [63:0] mix_const;
    logic [63:0] acc_sum;
    logic [63:0] z_fin;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_full;
    logic [31:0] mac_hi_sum;
    logic [31:0] a2;
    logic [31:0] a3;
    logic [31:0] m5;
    logic [31:0] rot5;
    logic [31:0] raw_out;
    logic [32:0] rem_trial;
    logic        rem_ge;

    assign span       = end_reg - start_reg + 32'd1;
    assign mix_const  = cmd.round ? xbr_pkg::MIX_MUL_B : xbr_pkg::MIX_MUL_A;
    assign acc_sum    = acc_reg + xbr_pkg::MIX_GAMMA;
    assign z_fin      = z_reg ^ (z_reg >> xbr_pkg::MIX_SHIFT_C);
    assign mac_hi_sum = mac_reg[63:32] + prod_reg[31:0];

    // One output step of xoshiro128**: multiplies by 5 and 9 are shift-and-add.
    assign a2      = gen_reg[2] ^ gen_reg[0];
    assign a3      = gen_reg[3] ^ gen_reg[1];
    assign m5      = gen_reg[1] + (gen_reg[1] << 2);
    assign rot5    = {m5[24:0], m5[31:25]};
    assign raw_out = rot5 + (rot5 << 3);

    // Restoring remainder step, one dividend bit per cycle.
    assign rem_trial = {rem_reg, div_reg[31]};
    assign rem_ge    = rem_trial >= {1'b0, span};

    always_comb begin
        unique case (cmd.op)
            xbr_pkg::OP_MUL0: begin
                mul_a = z_reg[31:0];
                mul_b = mix_const[31:0];
            end
            xbr_pkg::OP_MUL1: begin
                mul_a = z_reg[63:32];
                mul_b = mix_const[31:0];
            end
            xbr_pkg::OP_MUL2: begin
                mul_a = z_reg[31:0];
                mul_b = mix_const[63:32];
            end
            xbr_pkg::OP_SPAN_MUL: begin
                mul_a = draw_reg;
                mul_b = span;
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_full = 64'(mul_a) * 64'(mul_b);

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            xbr_pkg::OP_CAPTURE: begin
                kind_reg  <= s_tuser;
                seed_reg  <= s_tdata[31:0];
                start_reg <= s_tdata[63:32];
                end_reg   <= s_tdata[95:64];
            end
            xbr_pkg::OP_SEED:      acc_reg <= {32'd0, seed_reg};
            xbr_pkg::OP_SEED_ZERO: acc_reg <= 64'd0;
            xbr_pkg::OP_MIX_ADD: begin
                acc_reg <= acc_sum;
                z_reg   <= acc_sum;
            end
            xbr_pkg::OP_XOR: begin
                if (cmd.round) begin
                    z_reg <= z_reg ^ (z_reg >> xbr_pkg::MIX_SHIFT_B);
                end else begin
                    z_reg <= z_reg ^ (z_reg >> xbr_pkg::MIX_SHIFT_A);
                end
            end
            xbr_pkg::OP_MUL0: prod_reg <= mul_full;
            xbr_pkg::OP_MUL1: begin
                mac_reg  <= prod_reg;
                prod_reg <= mul_full;
            end
            xbr_pkg::OP_MUL2: begin
                mac_reg[63:32] <= mac_hi_sum;
                prod_reg       <= mul_full;
            end
            xbr_pkg::OP_MUL3: z_reg <= {mac_hi_sum, mac_reg[31:0]};
            xbr_pkg::OP_STORE: begin
                // Words shift in from the top, so the first one ends in word 0.
                gen_reg[0] <= gen_reg[1];
                gen_reg[1] <= gen_reg[2];
                gen_reg[2] <= gen_reg[3];
                gen_reg[3] <= z_fin[31:0];
            end
            xbr_pkg::OP_DRAW: begin
                draw_reg   <= raw_out;
                gen_reg[0] <= gen_reg[0] ^ a3;
                gen_reg[1] <= gen_reg[1] ^ a2;
                gen_reg[2] <= a2 ^ (gen_reg[1] << 9);
                gen_reg[3] <= {a3[20:0], a3[31:21]};
            end
            xbr_pkg::OP_SPAN_MUL: prod_reg <= mul_full;
            xbr_pkg::OP_DIV_INIT: begin
                rem_reg <= 32'd0;
                div_reg <= 32'd0 - span;
            end
            xbr_pkg::OP_DIV_STEP: begin
                rem_reg <= rem_ge ? 32'(rem_trial - {1'b0, span}) : rem_trial[31:0];
                div_reg <= div_reg << 1;
            end
            xbr_pkg::OP_RES_RAW: begin
                value_reg <= draw_reg;
                bad_reg   <= 1'b0;
            end
            xbr_pkg::OP_RES_RANGE: begin
                value_reg <= start_reg + prod_reg[63:32];
                bad_reg   <= 1'b0;
            end
            xbr_pkg::OP_RES_BAD: begin
                value_reg <= 32'd0;
                bad_reg   <= 1'b1;
            end
            xbr_pkg::OP_RES_ZERO: begin
                value_reg <= 32'd0;
                bad_reg   <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign status.kind         = kind_reg;
    assign status.range_bad    = (end_reg <= start_reg) || (span == 32'd0);
    assign status.low_lt_span  = prod_reg[31:0] < span;
    assign status.low_lt_limit = prod_reg[31:0] < rem_reg;

    assign res_value = value_reg;
    assign res_bad   = bad_reg;

endmodule

`default_nettype wire

>>> hdl/xbr_ctrl.sv
// Controller: sequences seed expansion, draws, rejection loop and remainder unit; owns the handshakes.
`default_nettype none

module xbr_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire xbr_pkg::xbr_status_t status,
    output xbr_pkg::xbr_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_MIX_ADD,
        S_XOR,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_STORE,
        S_DRAW,
        S_SPAN_MUL,
        S_CHECK,
        S_DIV,
        S_RESULT
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       word_reg, word_next;
    logic             round_reg, round_next;
    logic [4:0]       div_cnt_reg, div_cnt_next;
    logic             limit_ok_reg, limit_ok_next;
    logic             init_reg, init_next;
    logic             m_valid_reg, m_valid_next;
    xbr_pkg::xbr_op_t res_op_reg, res_op_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next    = state_reg;
        word_next     = word_reg;
        round_next    = round_reg;
        div_cnt_next  = div_cnt_reg;
        limit_ok_next = limit_ok_reg;
        init_next     = init_reg;
        res_op_next   = res_op_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        cmd.op        = xbr_pkg::OP_NONE;
        cmd.round     = round_reg;

        unique case (state_reg)
            S_INIT: begin
                cmd.op     = xbr_pkg::OP_SEED_ZERO;
                word_next  = 2'd0;
                state_next = S_MIX_ADD;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = xbr_pkg::OP_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                limit_ok_next = 1'b0;
                priority if (status.kind == xbr_pkg::KIND_RESEED) begin
                    cmd.op     = xbr_pkg::OP_SEED;
                    word_next  = 2'd0;
                    state_next = S_MIX_ADD;
                end else if (status.kind == xbr_pkg::KIND_RAW) begin
                    state_next = S_DRAW;
                end else if (status.kind == xbr_pkg::KIND_RANGE) begin
                    if (status.range_bad) begin
                        res_op_next = xbr_pkg::OP_RES_BAD;
                        state_next  = S_RESULT;
                    end else begin
                        state_next = S_DRAW;
                    end
                end else begin
                    res_op_next = xbr_pkg::OP_RES_ZERO;
                    state_next  = S_RESULT;
                end
            end
            S_MIX_ADD: begin
                cmd.op     = xbr_pkg::OP_MIX_ADD;
                round_next = 1'b0;
                state_next = S_XOR;
            end
            S_XOR: begin
                cmd.op     = xbr_pkg::OP_XOR;
                state_next = S_MUL0;
            end
            S_MUL0: begin
                cmd.op     = xbr_pkg::OP_MUL0;
                state_next = S_MUL1;
            end
            S_MUL1: begin
                cmd.op     = xbr_pkg::OP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2: begin
                cmd.op     = xbr_pkg::OP_MUL2;
                state_next = S_MUL3;
            end
            S_MUL3: begin
                cmd.op = xbr_pkg::OP_MUL3;
                if (round_reg) begin
                    state_next = S_STORE;
                end else begin
                    round_next = 1'b1;
                    state_next = S_XOR;
                end
            end
            S_STORE: begin
                cmd.op    = xbr_pkg::OP_STORE;
                word_next = word_reg + 2'd1;
                if (word_reg == 2'd3) begin
                    if (init_reg) begin
                        init_next  = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        res_op_next = xbr_pkg::OP_RES_ZERO;
                        state_next  = S_RESULT;
                    end
                end else begin
                    state_next = S_MIX_ADD;
                end
            end
            S_DRAW: begin
                cmd.op = xbr_pkg::OP_DRAW;
                if (status.kind == xbr_pkg::KIND_RAW) begin
                    res_op_next = xbr_pkg::OP_RES_RAW;
                    state_next  = S_RESULT;
                end else begin
                    state_next = S_SPAN_MUL;
                end
            end
            S_SPAN_MUL: begin
                cmd.op     = xbr_pkg::OP_SPAN_MUL;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                // The rejection limit is below the span, so a low product at or
                // above the span never needs the remainder.
                priority if (!status.low_lt_span) begin
                    res_op_next = xbr_pkg::OP_RES_RANGE;
                    state_next  = S_RESULT;
                end else if (!limit_ok_reg) begin
                    cmd.op       = xbr_pkg::OP_DIV_INIT;
                    div_cnt_next = 5'd0;
                    state_next   = S_DIV;
                end else if (status.low_lt_limit) begin
                    state_next = S_DRAW;
                end else begin
                    res_op_next = xbr_pkg::OP_RES_RANGE;
                    state_next  = S_RESULT;
                end
            end
            S_DIV: begin
                cmd.op       = xbr_pkg::OP_DIV_STEP;
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd31) begin
                    limit_ok_next = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    cmd.op       = res_op_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            word_reg     <= 2'd0;
            round_reg    <= 1'b0;
            div_cnt_reg  <= 5'd0;
            limit_ok_reg <= 1'b0;
            init_reg     <= 1'b1;
            m_valid_reg  <= 1'b0;
            res_op_reg   <= xbr_pkg::OP_RES_ZERO;
        end else begin
            state_reg    <= state_next;
            word_reg     <= word_next;
            round_reg    <= round_next;
            div_cnt_reg  <= div_cnt_next;
            limit_ok_reg <= limit_ok_next;
            init_reg     <= init_next;
            m_valid_reg  <= m_valid_next;
            res_op_reg   <= res_op_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/xoshiro128ss_bounded_random_unit.sv
// Top level of the xoshiro128** bounded random unit: controller plus datapath.
// A raw draw steps the generator once; a reseed runs the splitmix loop for all four words;
// a ranged draw adds the span multiply, the bit-serial rejection remainder when needed and
// a redraw per rejection; a refused range or unused kind goes straight to the result.
// One item is in work at a time; the bit-serial remainder and the splitmix word loop set the spacing.
// After reset the unit expands seed zero with s_tready low.
`default_nettype none

module xoshiro128ss_bounded_random_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [xbr_pkg::S_TDATA_W-1:0] s_tdata,  // seed, range_start, range_end
    input  wire logic [xbr_pkg::KIND_W-1:0]    s_tuser,  // kind
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [xbr_pkg::WORD_W-1:0]         m_tdata,  // value
    output logic                               m_tuser   // bad_range
);

    xbr_pkg::xbr_cmd_t    cmd;
    xbr_pkg::xbr_status_t status;

    xbr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    xbr_datapath u_datapath (
        .aclk      (aclk),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .status    (status),
        .res_value (m_tdata),
        .res_bad   (m_tuser)
    );

endmodule

`default_nettype wire

>>> hdl/xbr_checker.sv
// Port-level checker for the bounded random unit and its bind to the top level.
`default_nettype none

module xbr_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [xbr_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic [xbr_pkg::KIND_W-1:0]    s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [xbr_pkg::WORD_W-1:0]    m_tdata,
    input wire logic                          m_tuser
);

    // A result beat held back by the sink keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // A refused range always carries a zero value.
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("bad_range beat with nonzero value");

    // Reset starts the seed expansion, so nothing is taken or shown right after it.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("handshake active right after reset");

    // The unit works on one item at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input beat taken while an item is in work");

endmodule

bind xoshiro128ss_bounded_random_unit xbr_checker u_xbr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> sim/xoshiro128ss_result_checker.sv
// Stream checker for the bounded random unit: predicts every result and compares it.
`timescale 1ns / 100ps

module xoshiro128ss_result_checker
    import xbr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // seed, range_start, range_end
    input  logic [KIND_W-1:0]    s_tuser,  // kind
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [WORD_W-1:0]    m_tdata,  // value
    input  logic                 m_tuser,  // bad_range
    output int                   mismatch_count,
    output int                   awaited_count
);

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              bad_range;
    } draw_result_t;

    logic [WORD_W-1:0] gen_word [0:3];
    draw_result_t      awaited_results [$];
    int                failures = 0;

    function automatic logic [WORD_W-1:0] splitmix_finish(input logic [63:0] acc);
        logic [63:0] z;
        z = (acc ^ (acc >> MIX_SHIFT_A)) * MIX_MUL_A;
        z = (z ^ (z >> MIX_SHIFT_B)) * MIX_MUL_B;
        z = z ^ (z >> MIX_SHIFT_C);
        return z[WORD_W-1:0];
    endfunction

    function automatic void reseed_generator(input logic [WORD_W-1:0] seed);
        logic [63:0] acc;
        int          i;
        acc = {32'd0, seed};
        for (i = 0; i < 4; i++) begin
            acc = acc + MIX_GAMMA;
            gen_word[i] = splitmix_finish(acc);
        end
    endfunction

    // Returns the scrambled output taken from word 1, then steps the state.
    function automatic logic [WORD_W-1:0] advance_generator();
        logic [WORD_W-1:0] times5;
        logic [WORD_W-1:0] rotated;
        logic [WORD_W-1:0] shifted;
        times5  = gen_word[1] * 32'd5;
        rotated = {times5[24:0], times5[31:25]};
        shifted = gen_word[1] << 9;
        gen_word[2] = gen_word[2] ^ gen_word[0];
        gen_word[3] = gen_word[3] ^ gen_word[1];
        gen_word[1] = gen_word[1] ^ gen_word[2];
        gen_word[0] = gen_word[0] ^ gen_word[3];
        gen_word[2] = gen_word[2] ^ shifted;
        gen_word[3] = {gen_word[3][20:0], gen_word[3][31:21]};
        return rotated * 32'd9;
    endfunction

    // Multiply-and-reject: redraw while the low product word is under the threshold.
    function automatic logic [WORD_W-1:0] scale_into_span(input logic [WORD_W-1:0] span);
        logic [63:0]       product;
        logic [WORD_W-1:0] reject_below;
        product = {32'd0, advance_generator()} * {32'd0, span};
        if (product[31:0] < span) begin
            reject_below = (32'd0 - span) % span;
            while (product[31:0] < reject_below)
                product = {32'd0, advance_generator()} * {32'd0, span};
        end
        return product[63:32];
    endfunction

    function automatic draw_result_t predict_result(input logic [KIND_W-1:0] kind,
                                                    input logic [WORD_W-1:0] seed,
                                                    input logic [WORD_W-1:0] lo,
                                                    input logic [WORD_W-1:0] hi);
        draw_result_t      res;
        logic [WORD_W-1:0] span;
        res  = '0;
        span = hi - lo + 32'd1;
        case (kind)
            KIND_RESEED: reseed_generator(seed);
            KIND_RAW:    res.value = advance_generator();
            KIND_RANGE: begin
                // A single-value or inverted range and a span that wraps to zero are all refused.
                if (hi <= lo || span == 32'd0)
                    res.bad_range = 1'b1;
                else
                    res.value = lo + scale_into_span(span);
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin : beat_watch
        draw_result_t due;
        if (!aresetn) begin
            reseed_generator(32'd0);
            awaited_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result beat with nothing awaited: value %h, bad_range %b",
                           m_tdata, m_tuser);
                    failures++;
                end else begin
                    due = awaited_results.pop_front();
                    if (m_tdata !== due.value) begin
                        $error("value: expected %h, got %h", due.value, m_tdata);
                        failures++;
                    end
                    if (m_tuser !== due.bad_range) begin
                        $error("bad_range: expected %b, got %b", due.bad_range, m_tuser);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(predict_result(s_tuser, s_tdata[31:0],
                                                         s_tdata[63:32], s_tdata[95:64]));
        end
        mismatch_count <= failures;
        awaited_count  <= awaited_results.size();
    end

endmodule

>>> sim/xoshiro128ss_bounded_random_unit_test.sv
// Stimulus and verdict for the bounded random unit; the checker runs beside the block.
`timescale 1ns / 100ps

module xoshiro128ss_bounded_random_unit_test;
    import xbr_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS        = 1625;
    localparam int BACKPRESSURE_START  = 3000;
    localparam int BACKPRESSURE_CYCLES = 600;
    localparam int DRAIN_CYCLES        = 100;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // seed, range_start, range_end
    logic [KIND_W-1:0]    s_tuser  = '0;  // kind
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [WORD_W-1:0]    m_tdata;         // value
    logic                 m_tuser;         // bad_range
    int                   mismatch_count;
    int                   awaited_count;
    bit                   sender_eager = 1'b0;

    xoshiro128ss_bounded_random_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    xoshiro128ss_result_checker result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Mostly no idling, some short gaps and an occasional long one.
    function automatic int unsigned idle_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic offer_item(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] seed,
                              input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
        int unsigned gap;
        gap = sender_eager ? 0 : idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= kind;
        s_tdata  <= {hi, lo, seed};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic offer_random_item();
        int unsigned       roll;
        int unsigned       shape;
        logic [WORD_W-1:0] span;
        logic [WORD_W-1:0] seed;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [KIND_W-1:0] kind;
        roll = $urandom_range(0, 99);
        seed = $urandom;
        lo   = $urandom;
        hi   = $urandom;
        span = 32'd2;
        if (roll < 6)
            kind = KIND_RESEED;
        else if (roll < 40)
            kind = KIND_RAW;
        else if (roll < 43)
            kind = KIND_UNUSED;
        else begin
            kind  = KIND_RANGE;
            shape = $urandom_range(0, 9);
            case (shape)
                0, 1: span = $urandom_range(2, 16);
                // Spans just above half the word reject close to half of all draws.
                2, 3: span = 32'h8000_0000 + $urandom_range(1, 32'h0FFF_FFFF);
                4, 5: span = $urandom_range(2, 32'hFFFF_FFFF);
                6:    span = 32'hFFFF_FFFF - $urandom_range(0, 15);
                7:    span = 32'd1 << $urandom_range(1, 31);
                8:    hi = $urandom_range(0, lo);
                default: begin
                    if ($urandom_range(0, 1)) begin
                        lo = '0;
                        hi = '1;
                    end else begin
                        hi = lo;
                    end
                end
            endcase
            if (shape < 8) begin
                lo = $urandom_range(0, 32'hFFFF_FFFF - (span - 32'd1));
                hi = lo + span - 32'd1;
            end
        end
        offer_item(kind, seed, lo, hi);
    endtask

    initial begin : stimulus
        int i;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Draws straight from the reset state, then the range corners, unused kinds and reseeds with draws.
        offer_item(KIND_RAW, '0, '0, '0);
        offer_item(KIND_RAW, '1, '1, '1);
        offer_item(KIND_RANGE, $urandom, 32'd0, 32'd1);
        offer_item(KIND_RANGE, $urandom, 32'd0, 32'hFFFF_FFFE);
        offer_item(KIND_RANGE, $urandom, 32'd1, 32'hFFFF_FFFF);
        offer_item(KIND_RANGE, $urandom, 32'd0, 32'hFFFF_FFFF);
        offer_item(KIND_RANGE, $urandom, 32'd5, 32'd5);
        offer_item(KIND_RANGE, $urandom, 32'hFFFF_FFFF, 32'd0);
        offer_item(KIND_RANGE, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_item(KIND_RANGE, $urandom, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        for (i = 0; i < 3; i++)
            offer_item(KIND_RANGE, $urandom, 32'd0, 32'h8000_0000);
        offer_item(KIND_RANGE, $urandom, 32'd100, 32'd102);
        offer_item(KIND_RANGE, $urandom, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        offer_item(KIND_UNUSED, '1, '1, '1);
        offer_item(KIND_UNUSED, '0, '0, '0);
        offer_item(KIND_RESEED, 32'd0, '1, '1);
        offer_item(KIND_RAW, '0, '0, '0);
        offer_item(KIND_RESEED, 32'hFFFF_FFFF, '0, '0);
        offer_item(KIND_RAW, '0, '0, '0);
        offer_item(KIND_RESEED, $urandom, $urandom, $urandom);
        offer_item(KIND_RAW, '0, '0, '0);
        offer_item(KIND_RAW, '1, '1, '1);

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0)
                sender_eager = ($urandom_range(0, 3) == 0);
            offer_random_item();
        end
        s_tvalid <= 1'b0;

        // One more edge so the checker's count includes the last accepted beat.
        @(posedge aclk);
        while (awaited_count != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : result_sink
        int unsigned cycle_count;
        int unsigned hold_left;
        int unsigned mode_left;
        bit          always_ready;
        cycle_count  = 0;
        hold_left    = 0;
        mode_left    = 0;
        always_ready = 1'b0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (mode_left == 0) begin
                always_ready = ($urandom_range(0, 3) == 0);
                mode_left    = $urandom_range(100, 400);
            end
            mode_left--;
            // One long hold-off lets the unit fill up and push back on its input.
            if (cycle_count == BACKPRESSURE_START)
                hold_left = BACKPRESSURE_CYCLES;
            else if (hold_left == 0 && !always_ready)
                hold_left = idle_gap();
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #3_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
